@@ hw/rtl/dhse_pkg.sv @@
// Shared types and constants for the double hashing set engine.
`timescale 1ns / 1ps
package dhse_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;

  localparam logic [1:0] DIV_KEY_N  = 2'd0;
  localparam logic [1:0] DIV_KEY_P  = 2'd1;
  localparam logic [1:0] DIV_STEP_N = 2'd2;

  localparam logic [1:0] CFG_TABLE_SIZE   = 2'd0;
  localparam logic [1:0] CFG_SECOND_PRIME = 2'd1;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DIV1   = 9'b000000100,
    ST_DIV2   = 9'b000001000,
    ST_DIV3   = 9'b000010000,
    ST_PROBE  = 9'b000100000,
    ST_DRAIN  = 9'b001000000,
    ST_COMMIT = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       h1_save;
    logic       h2m_save;
    logic       probe_init;
    logic       probe_run;
    logic       commit;
    logic       out_load;
    logic       clr_run;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic probe_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

@@ hw/rtl/dhse_divmod.sv @@
// Bit-serial remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module dhse_divmod #(
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);
  logic [31:0]   dvd_r, dvd_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   shf;
  logic [DW:0]   dif;

  always_comb begin
    shf      = {rem_r, dvd_r[31]};
    dif      = shf - {1'b0, dvs_r};
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[30:0], 1'b0};
      rem_nxt = (shf >= {1'b0, dvs_r}) ? dif[DW-1:0] : shf[DW-1:0];
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule

@@ hw/rtl/dhse_ctrl.sv @@
// Controller state machine of the double hashing set engine.
`timescale 1ns / 1ps
module dhse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  dhse_pkg::stat_t st,
  output dhse_pkg::ctrl_t ctl
);
  import dhse_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.clr_run = 1'b1;
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load      = 1'b1;
          ctl.div_start = 1'b1;
          ctl.div_sel   = DIV_KEY_N;
          state_nxt     = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (st.div_done) begin
          ctl.h1_save   = 1'b1;
          ctl.div_start = 1'b1;
          ctl.div_sel   = DIV_KEY_P;
          state_nxt     = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (st.div_done) begin
          ctl.div_start = 1'b1;
          ctl.div_sel   = DIV_STEP_N;
          state_nxt     = ST_DIV3;
        end
      end
      ST_DIV3: begin
        if (st.div_done) begin
          ctl.h2m_save   = 1'b1;
          ctl.probe_init = 1'b1;
          state_nxt      = ST_PROBE;
        end
      end
      ST_PROBE: begin
        ctl.probe_run = 1'b1;
        if (st.probe_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end
endmodule

@@ hw/rtl/dhse_datapath.sv @@
// Datapath of the double hashing set engine: hashes, probe walk, slot memory, count.
`timescale 1ns / 1ps
module dhse_datapath #(
  parameter int CAPACITY = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dhse_pkg::ctrl_t ctl,
  output dhse_pkg::stat_t st,
  input  logic [1:0]      in_command,
  input  logic [31:0]     in_key,
  input  logic [10:0]     table_size,
  input  logic [9:0]      second_prime,
  input  logic            out_tready,
  output logic            out_tvalid,
  output logic            out_found,
  output logic            out_status,
  output logic [10:0]     out_entry_count
);
  import dhse_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int DW = (NW > 10) ? NW : 10;

  logic [NW-1:0] n_eff;
  logic [9:0]    p_eff;
  logic [31:0]   dvd;
  logic [DW-1:0] dvs;
  logic          div_done;
  logic [DW-1:0] div_rem;
  logic [9:0]    h2;

  logic [1:0]    cmd_r;
  logic [31:0]   key_r;
  logic [NW-1:0] h1_r, h2m_r;
  logic [NW-1:0] s_r, s_nxt;
  logic [NW-1:0] i_r;
  logic [NW:0]   sum;

  logic [32:0]   mem [CAPACITY];
  logic [32:0]   rd_q;
  logic [AW-1:0] rd_slot_r;
  logic          rd_vld_r;
  logic [AW-1:0] clr_r;

  logic          match_r, free_r;
  logic [AW-1:0] match_at_r, free_at_r;

  logic [NW-1:0] cnt_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [32:0]   wdata;

  logic          res_found_r, res_status_r;
  logic          ov_r;
  logic          of_r, os_r;
  logic [NW+10:0] cnt_ext;
  logic [10:0]   oc_r;

  always_comb begin
    if (table_size == 11'd0) begin
      n_eff = NW'(1);
    end else if ({21'd0, table_size} > 32'(CAPACITY)) begin
      n_eff = NW'(CAPACITY);
    end else begin
      n_eff = NW'(table_size);
    end
    p_eff = (second_prime == 10'd0) ? 10'd1 : second_prime;
    h2    = p_eff - div_rem[9:0];
    unique case (ctl.div_sel)
      DIV_KEY_P: begin
        dvd = in_key;
        dvs = DW'(p_eff);
      end
      DIV_STEP_N: begin
        dvd = {22'd0, h2};
        dvs = DW'(n_eff);
      end
      default: begin
        dvd = in_key;
        dvs = DW'(n_eff);
      end
    endcase
    if (ctl.div_sel != DIV_KEY_N) dvd = (ctl.div_sel == DIV_STEP_N) ? {22'd0, h2} : key_r;
    else                          dvd = in_key;
  end

  dhse_divmod #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    sum   = {1'b0, s_r} + {1'b0, h2m_r};
    s_nxt = (sum >= {1'b0, n_eff}) ? NW'(sum - {1'b0, n_eff}) : sum[NW-1:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_r;
    wdata = '0;
    if (ctl.clr_run) begin
      we = 1'b1;
    end else if (ctl.commit) begin
      if (cmd_r == CMD_INSERT && !match_r && free_r) begin
        we    = 1'b1;
        waddr = free_at_r;
        wdata = {1'b1, key_r};
      end else if (cmd_r == CMD_DELETE && match_r) begin
        we    = 1'b1;
        waddr = match_at_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[s_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      key_r <= in_key;
    end
    if (ctl.h1_save) h1_r <= div_rem[NW-1:0];
    if (ctl.h2m_save) h2m_r <= div_rem[NW-1:0];
    if (ctl.probe_init) begin
      s_r <= h1_r;
      i_r <= NW'(1);
    end else if (ctl.probe_run) begin
      s_r <= s_nxt;
      i_r <= i_r + NW'(1);
    end
    rd_slot_r <= s_nxt[AW-1:0];
    if (rd_vld_r) begin
      if (rd_q[32]) begin
        if (!match_r && rd_q[31:0] == key_r) match_at_r <= rd_slot_r;
      end else if (!free_r) begin
        free_at_r <= rd_slot_r;
      end
    end
    if (ctl.commit) begin
      res_found_r  <= match_r;
      res_status_r <= (cmd_r == CMD_INSERT) && !match_r && !free_r;
    end
    if (ctl.out_load) begin
      of_r <= res_found_r;
      os_r <= res_status_r;
      oc_r <= cnt_ext[10:0];
    end
  end

  assign cnt_ext = {11'd0, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      match_r  <= 1'b0;
      free_r   <= 1'b0;
      clr_r    <= '0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      rd_vld_r <= ctl.probe_run;
      if (ctl.clr_run) clr_r <= clr_r + AW'(1);
      if (ctl.probe_init) begin
        match_r <= 1'b0;
        free_r  <= 1'b0;
      end else if (rd_vld_r) begin
        if (rd_q[32]) begin
          if (rd_q[31:0] == key_r) match_r <= 1'b1;
        end else begin
          free_r <= 1'b1;
        end
      end
      if (ctl.commit) begin
        if (cmd_r == CMD_INSERT && !match_r && free_r) cnt_r <= cnt_r + NW'(1);
        else if (cmd_r == CMD_DELETE && match_r && cnt_r != '0) cnt_r <= cnt_r - NW'(1);
      end
      if (ctl.out_load)  ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  assign st.div_done   = div_done;
  assign st.probe_last = (i_r == n_eff);
  assign st.clr_last   = (clr_r == AW'(CAPACITY - 1));
  assign st.out_free   = !ov_r || out_tready;

  assign out_tvalid      = ov_r;
  assign out_found       = of_r;
  assign out_status      = os_r;
  assign out_entry_count = oc_r;
endmodule

@@ hw/rtl/double_hash_set_engine_top.sv @@
// Top level of the double hashing set engine.
`timescale 1ns / 1ps
//  Port group  Direction  Beat contents
//  in_*        slave      command, key
//  out_*       master     found, status, entry_count
//  cfg_*       write      table_size (index 0), second_prime (index 1)
// An item goes through serial remainder work (key mod N, key mod P, step mod N),
// then probing through the slot memory port. After reset a clearing pass empties
// the slot memory; no beat is taken meanwhile. A new beat is taken while the
// previous result waits.
module double_hash_set_engine_top #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] command, [33:2] key
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] found, [1] status, [12:2] entry_count
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);
  import dhse_pkg::*;

  ctrl_t       ctl;
  stat_t       st;
  logic [10:0] tsz_r;
  logic [9:0]  sp_r;
  logic        o_found, o_status;
  logic [10:0] o_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsz_r <= 11'd11;
      sp_r  <= 10'd7;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TABLE_SIZE)   tsz_r <= cfg_wdata;
      if (cfg_index == CFG_SECOND_PRIME) sp_r  <= cfg_wdata[9:0];
    end
  end

  dhse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .ctl       (ctl)
  );

  dhse_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .st              (st),
    .in_command      (in_tdata[1:0]),
    .in_key          (in_tdata[33:2]),
    .table_size      (tsz_r),
    .second_prime    (sp_r),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_found       (o_found),
    .out_status      (o_status),
    .out_entry_count (o_count)
  );

  assign out_tdata = {3'd0, o_count, o_status, o_found};
endmodule
